// File: src/sbrc_pkg.sv
package sbrc_pkg;

  localparam int MEM_WORDS = 8192;
  localparam int MEM_AW    = $clog2(MEM_WORDS);
  localparam int REG_COUNT = 8;
  localparam int REG_AW    = 3;

  // Function codes of an input item.
  localparam logic [1:0] FN_LOAD  = 2'd0;
  localparam logic [1:0] FN_EXEC  = 2'd1;
  localparam logic [1:0] FN_RDMEM = 2'd2;
  localparam logic [1:0] FN_RDREG = 2'd3;

  // Major opcodes, instruction bits 15:13.
  localparam logic [2:0] OP_ALU  = 3'd0;
  localparam logic [2:0] OP_ADDI = 3'd1;
  localparam logic [2:0] OP_J    = 3'd2;
  localparam logic [2:0] OP_JAL  = 3'd3;
  localparam logic [2:0] OP_LW   = 3'd4;
  localparam logic [2:0] OP_SW   = 3'd5;
  localparam logic [2:0] OP_JEQ  = 3'd6;
  localparam logic [2:0] OP_SLTI = 3'd7;

  // Function nibble under OP_ALU.
  localparam logic [3:0] FT_ADD = 4'd0;
  localparam logic [3:0] FT_SUB = 4'd1;
  localparam logic [3:0] FT_OR  = 4'd2;
  localparam logic [3:0] FT_AND = 4'd3;
  localparam logic [3:0] FT_SLT = 4'd4;
  localparam logic [3:0] FT_JR  = 4'd8;

  localparam logic [2:0] LINK_REG = 3'd7;

  typedef struct packed {
    logic [1:0]  func;
    logic [12:0] addr;
    logic [15:0] data;
  } in_t;

  typedef struct packed {
    logic [15:0] pc_now;
    logic        halted;
    logic [15:0] read_data;
    logic        reg_written;
    logic [2:0]  reg_index;
    logic [15:0] reg_value;
    logic        mem_written;
    logic [12:0] mem_addr;
    logic [15:0] mem_value;
  } out_t;

  // Masks to 13 bits and folds into the memory size. The quotient is at most
  // seven, so each candidate subtraction is checked in parallel.
  function automatic logic [MEM_AW-1:0] mem_index(input logic [15:0] a);
    logic [12:0] m;
    logic [12:0] r;
    m = a[12:0];
    r = m;
    for (int k = 1; k < 8; k++) begin
      if ((k * MEM_WORDS < 8192) && (int'(m) >= k * MEM_WORDS)) begin
        r = m - 13'(k * MEM_WORDS);
      end
    end
    return r[MEM_AW-1:0];
  endfunction

endpackage

// File: src/sixteen_bit_risc_core_step.sv
// Channel | Ports                           | Moves
// in      | in_valid, in_stall, in_data     | one request item (func, addr, data)
// out     | out_valid, out_stall, out_data  | one result item per request
//
// A memory read, register read or store item finishes in the decode phase of the engine,
// an executed instruction after the execute phase (fetch, then operand read and execute),
// and lw after the load phase, set by the synchronous read of the 8192-word memory.
// The next item is accepted in the cycle the current result is registered.
// After reset a clearing pass writes zero to every memory word, one per cycle,
// while in_stall stays high.
// out_stall holds the result register; the engine waits on its final step.
module sixteen_bit_risc_core_step (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  sbrc_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output sbrc_pkg::out_t  out_data
);

  typedef enum logic [1:0] {PH_DEC, PH_EXE, PH_LW} phase_t;

  // Memory and its read register, with a write-first bypass.
  logic [15:0]                 mem [sbrc_pkg::MEM_WORDS];
  logic [15:0]                 mem_q_r;
  logic                        mem_byp_r;
  logic [15:0]                 mem_byp_d_r;
  logic [15:0]                 mem_rd;
  logic                        mem_re, mem_we;
  logic [sbrc_pkg::MEM_AW-1:0] mem_ra, mem_wa;
  logic [15:0]                 mem_wd;

  // Register file with two read ports.
  logic [15:0]                    rf [sbrc_pkg::REG_COUNT];
  logic [sbrc_pkg::REG_COUNT-1:0] rf_valid_r;
  logic [15:0]                    rfa_q_r, rfb_q_r, rfa_byp_d_r;
  logic                           rfa_ok_r, rfb_ok_r, rfa_byp_r;
  logic [15:0]                    rfa, rfb;
  logic                           rf_re_a, rf_re_b, rf_we;
  logic [sbrc_pkg::REG_AW-1:0]    rf_ra, rf_rb, rf_wa;
  logic [15:0]                    rf_wd;

  // Engine state.
  logic                        busy_r;
  phase_t                      phase_r;
  sbrc_pkg::in_t               item_r;
  logic [15:0]                 inst_r;
  logic [15:0]                 pc_r, pc_nxt;
  logic                        halt_r, halt_nxt;
  logic                        clr_busy_r;
  logic [sbrc_pkg::MEM_AW-1:0] clr_addr_r;
  logic                        out_valid_r;
  sbrc_pkg::out_t              out_r, res;

  logic accept, fin, last, out_free, dec_go;

  // Execute-phase decode.
  logic [2:0]                  op;
  logic [15:0]                 simm, imm7, tgt, pc_inc;
  logic [15:0]                 ex_next, ex_wv;
  logic                        ex_halt, ex_wr, ex_sw;
  logic [2:0]                  ex_wi;
  logic [sbrc_pkg::MEM_AW-1:0] ls_addr;
  logic                        wr;
  logic [2:0]                  wi;
  logic [15:0]                 wv;

  assign mem_rd = mem_byp_r ? mem_byp_d_r : mem_q_r;
  assign rfa    = rfa_byp_r ? rfa_byp_d_r : (rfa_ok_r ? rfa_q_r : 16'd0);
  assign rfb    = rfb_ok_r ? rfb_q_r : 16'd0;

  assign out_free = !out_valid_r || !out_stall;
  assign last = (phase_r == PH_DEC && !(item_r.func == sbrc_pkg::FN_EXEC && !halt_r)) ||
                (phase_r == PH_EXE && inst_r[15:13] != sbrc_pkg::OP_LW) ||
                (phase_r == PH_LW);
  assign fin      = busy_r && last && out_free;
  assign in_stall = clr_busy_r || (busy_r && !fin);
  assign accept   = in_valid && !in_stall;
  assign dec_go   = busy_r && phase_r == PH_DEC && item_r.func == sbrc_pkg::FN_EXEC && !halt_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    op      = inst_r[15:13];
    simm    = {{9{inst_r[6]}}, inst_r[6:0]};
    imm7    = {9'd0, inst_r[6:0]};
    tgt     = {3'd0, inst_r[12:0]};
    pc_inc  = pc_r + 16'd1;
    ex_next = pc_inc;
    ex_halt = 1'b0;
    ex_wr   = 1'b0;
    ex_wi   = inst_r[9:7];
    ex_wv   = 16'd0;
    ex_sw   = 1'b0;
    ls_addr = sbrc_pkg::mem_index(rfa + simm);
    case (op)
      sbrc_pkg::OP_ALU: begin
        ex_wi = inst_r[6:4];
        ex_wr = 1'b1;
        case (inst_r[3:0])
          sbrc_pkg::FT_ADD: ex_wv = rfa + rfb;
          sbrc_pkg::FT_SUB: ex_wv = rfa - rfb;
          sbrc_pkg::FT_OR:  ex_wv = rfa | rfb;
          sbrc_pkg::FT_AND: ex_wv = rfa & rfb;
          sbrc_pkg::FT_SLT: ex_wv = {15'd0, rfa < rfb};
          sbrc_pkg::FT_JR: begin
            ex_wr   = 1'b0;
            ex_halt = (rfa == pc_r);
            ex_next = rfa;
          end
          default: ex_wr = 1'b0;
        endcase
      end
      sbrc_pkg::OP_ADDI: begin
        ex_wr = 1'b1;
        ex_wv = rfa + simm;
      end
      sbrc_pkg::OP_J: begin
        ex_halt = (tgt == pc_r);
        ex_next = tgt;
      end
      sbrc_pkg::OP_JAL: begin
        ex_halt = (tgt == pc_r);
        ex_next = tgt;
        ex_wr   = 1'b1;
        ex_wi   = sbrc_pkg::LINK_REG;
        ex_wv   = pc_inc;
      end
      sbrc_pkg::OP_LW: ex_wr = 1'b0;
      sbrc_pkg::OP_SW: ex_sw = 1'b1;
      sbrc_pkg::OP_JEQ: begin
        if (rfa == rfb) begin
          ex_halt = (simm == 16'hFFFF);
          ex_next = pc_inc + simm;
        end
      end
      default: begin
        ex_wr = 1'b1;
        ex_wv = {15'd0, rfa < imm7};
      end
    endcase
  end

  always_comb begin
    mem_re   = 1'b0;
    mem_ra   = '0;
    mem_we   = clr_busy_r;
    mem_wa   = clr_addr_r;
    mem_wd   = 16'd0;
    rf_re_a  = 1'b0;
    rf_ra    = '0;
    rf_re_b  = 1'b0;
    rf_rb    = '0;
    wr       = 1'b0;
    wi       = '0;
    wv       = 16'd0;
    pc_nxt   = pc_r;
    halt_nxt = halt_r;
    res      = '0;
    if (fin) begin
      case (item_r.func)
        sbrc_pkg::FN_LOAD: begin
          mem_we          = 1'b1;
          mem_wa          = sbrc_pkg::mem_index({3'd0, item_r.addr});
          mem_wd          = item_r.data;
          res.mem_written = 1'b1;
          res.mem_addr    = 13'(mem_wa);
          res.mem_value   = item_r.data;
        end
        sbrc_pkg::FN_RDMEM: res.read_data = mem_rd;
        sbrc_pkg::FN_RDREG: res.read_data = rfa;
        sbrc_pkg::FN_EXEC: begin
          if (!halt_r) begin
            if (phase_r == PH_LW) begin
              wr     = 1'b1;
              wi     = inst_r[9:7];
              wv     = mem_rd;
              pc_nxt = pc_inc;
            end else begin
              wr       = ex_wr;
              wi       = ex_wi;
              wv       = ex_wv;
              pc_nxt   = ex_next;
              halt_nxt = ex_halt;
              if (ex_sw) begin
                mem_we          = 1'b1;
                mem_wa          = ls_addr;
                mem_wd          = rfb;
                res.mem_written = 1'b1;
                res.mem_addr    = 13'(ls_addr);
                res.mem_value   = rfb;
              end
            end
          end
        end
        default: ;
      endcase
      res.pc_now = pc_nxt;
      res.halted = halt_nxt;
      if (wr && wi != 3'd0) begin
        res.reg_written = 1'b1;
        res.reg_index   = wi;
        res.reg_value   = wv;
      end
    end
    rf_we = fin && wr && wi != 3'd0;
    rf_wa = wi;
    rf_wd = wv;

    // Reads issued by a new item see the pc and stores of the item finishing now.
    if (accept) begin
      case (in_data.func)
        sbrc_pkg::FN_EXEC: begin
          mem_re = 1'b1;
          mem_ra = sbrc_pkg::mem_index(pc_nxt);
        end
        sbrc_pkg::FN_RDMEM: begin
          mem_re = 1'b1;
          mem_ra = sbrc_pkg::mem_index({3'd0, in_data.addr});
        end
        sbrc_pkg::FN_RDREG: begin
          rf_re_a = 1'b1;
          rf_ra   = in_data.addr[2:0];
        end
        default: ;
      endcase
    end
    if (dec_go) begin
      rf_re_a = 1'b1;
      rf_ra   = mem_rd[12:10];
      rf_re_b = 1'b1;
      rf_rb   = mem_rd[9:7];
    end
    if (busy_r && phase_r == PH_EXE && op == sbrc_pkg::OP_LW) begin
      mem_re = 1'b1;
      mem_ra = ls_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_q_r     <= mem[mem_ra];
      mem_byp_r   <= mem_we && (mem_wa == mem_ra);
      mem_byp_d_r <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf[rf_wa] <= rf_wd;
    end
    if (rf_re_a) begin
      rfa_q_r     <= rf[rf_ra];
      rfa_ok_r    <= rf_valid_r[rf_ra];
      rfa_byp_r   <= rf_we && (rf_wa == rf_ra);
      rfa_byp_d_r <= rf_wd;
    end
    if (rf_re_b) begin
      rfb_q_r  <= rf[rf_rb];
      rfb_ok_r <= rf_valid_r[rf_rb];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      phase_r     <= PH_DEC;
      pc_r        <= 16'd0;
      halt_r      <= 1'b0;
      rf_valid_r  <= '0;
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      halt_r <= halt_nxt;
      if (rf_we) begin
        rf_valid_r[rf_wa] <= 1'b1;
      end
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == sbrc_pkg::MEM_AW'(sbrc_pkg::MEM_WORDS - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (accept) begin
        busy_r  <= 1'b1;
        phase_r <= PH_DEC;
      end else if (fin) begin
        busy_r <= 1'b0;
      end else if (busy_r && !last) begin
        phase_r <= (phase_r == PH_DEC) ? PH_EXE : PH_LW;
      end
      if (fin) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    if (dec_go) begin
      inst_r <= mem_rd;
    end
    if (fin) begin
      out_r <= res;
    end
  end

`ifndef SYNTHESIS
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !accept)
    else $error("item accepted during memory clearing pass");

  a_halt_holds_pc: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> $stable(pc_r) && halt_r)
    else $error("pc or halt flag changed after halt");

  a_port_b_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    rf_re_b |-> !rf_we)
    else $error("operand read overlaps a register write");

  a_lw_phase: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && phase_r == PH_LW |-> inst_r[15:13] == sbrc_pkg::OP_LW)
    else $error("load phase entered for a non-load instruction");

  a_fin_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    fin |=> out_valid_r && !busy_r || accept == 1'b0 && out_valid_r || out_valid_r)
    else $error("finished item did not reach the output register");
`endif

endmodule
